/* sv/seir_pkg.sv */
`timescale 1ns / 1ps
package seir_pkg;

  // fixed model constants, Q4.28 rates and Q24.16 populations
  localparam logic [63:0] MU_H    = 64'd10506;
  localparam logic [63:0] THETA_H = 64'd256501;
  localparam logic [63:0] MU_R    = 64'd490293;
  localparam logic [63:0] THETA_R = 64'd1197005;
  localparam logic [63:0] DELTA_R = 64'd8053064;
  localparam logic [63:0] ALPHA3  = 64'd38347922;
  localparam logic [63:0] K4      = MU_R + ALPHA3;
  localparam logic [63:0] K5      = MU_R + DELTA_R;
  localparam logic signed [63:0] ONE_Q16 = 64'sd65536;
  localparam logic signed [63:0] POP_MAX = 64'sd549755813887;
  localparam logic signed [63:0] POP_MIN = -64'sd549755813888;

  // divider: 40-bit magnitude shifted up by 28 fraction bits
  localparam int DIV_BITS = 68;

  localparam int NUM_CFG = 8;
  localparam logic [31:0] CFG_RESET [NUM_CFG] = '{
    32'd26844, 32'd2684355, 32'd33554432, 32'd26843546,
    32'd12782640, 32'd19173962, 32'd268435, 32'd0
  };

  // register indexes
  localparam logic [2:0] REG_BETA1 = 3'd0;
  localparam logic [2:0] REG_BETA3 = 3'd1;
  localparam logic [2:0] REG_A1    = 3'd2;
  localparam logic [2:0] REG_A2    = 3'd3;
  localparam logic [2:0] REG_NU    = 3'd4;
  localparam logic [2:0] REG_TAU   = 3'd5;
  localparam logic [2:0] REG_PHI   = 3'd6;
  localparam logic [2:0] REG_IMP   = 3'd7;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [31:0]        step_size;
    logic [31:0]        contact_rate_human;
    logic signed [39:0] susceptible_humans;
    logic signed [39:0] exposed_humans;
    logic signed [39:0] infectious_humans;
    logic signed [39:0] isolated_humans;
    logic signed [39:0] recovered_humans;
    logic signed [39:0] susceptible_rodents;
    logic signed [39:0] exposed_rodents;
    logic signed [39:0] infectious_rodents;
  } seir_in_t;

  typedef struct packed {
    logic signed [39:0] susceptible_humans_now;
    logic signed [39:0] exposed_humans_now;
    logic signed [39:0] infectious_humans_now;
    logic signed [39:0] isolated_humans_now;
    logic signed [39:0] recovered_humans_now;
    logic signed [39:0] susceptible_rodents_now;
    logic signed [39:0] exposed_rodents_now;
    logic signed [39:0] infectious_rodents_now;
    logic signed [39:0] active_infections;
    logic               saturated;
  } seir_out_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_WAIT_MUL, ST_WAIT_DIV, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    OP_LD, OP_ADD, OP_SUB, OP_MAC, OP_MSUB, OP_DIV, OP_ST, OP_STF, OP_SAT, OP_END
  } op_t;

  // operand and destination locations
  typedef enum logic [5:0] {
    L_ZERO,
    L_H0, L_H1, L_H2, L_H3, L_H4,
    L_R0, L_R1, L_R2,
    L_NH, L_NR, L_RATIO_R, L_RATIO_H, L_FOI_H, L_FOI_R, L_INF_H, L_INF_R,
    L_K1, L_K2, L_K3,
    L_D0, L_D1, L_D2, L_D3, L_D4, L_D5, L_D6, L_D7,
    L_STEP, L_BETA1, L_BETA2, L_BETA3,
    L_A1, L_A2, L_NU, L_TAU, L_PHI, L_IMP,
    L_MU_H, L_MU_R, L_ALPHA3, L_K4, L_K5, L_THETA_H, L_THETA_R
  } loc_t;

  typedef struct packed {
    op_t  op;
    loc_t a;
    loc_t b;
    loc_t d;
  } uop_t;

  localparam int PC_W = 7;

  function automatic uop_t mk(input op_t op, input loc_t a, input loc_t b, input loc_t d);
    uop_t u;
    u.op = op;
    u.a  = a;
    u.b  = b;
    u.d  = d;
    return u;
  endfunction

  // microprogram for one euler step
  function automatic uop_t seir_ucode(input logic [PC_W-1:0] pc);
    uop_t u;
    u = mk(OP_END, L_ZERO, L_ZERO, L_ZERO);
    case (pc)
      // combined rate coefficients
      7'd0:  u = mk(OP_LD,   L_A1,      L_ZERO,  L_ZERO);
      7'd1:  u = mk(OP_ADD,  L_A2,      L_ZERO,  L_ZERO);
      7'd2:  u = mk(OP_ADD,  L_MU_H,    L_ZERO,  L_ZERO);
      7'd3:  u = mk(OP_ST,   L_ZERO,    L_ZERO,  L_K1);
      7'd4:  u = mk(OP_LD,   L_NU,      L_ZERO,  L_ZERO);
      7'd5:  u = mk(OP_ADD,  L_MU_H,    L_ZERO,  L_ZERO);
      7'd6:  u = mk(OP_ST,   L_ZERO,    L_ZERO,  L_K2);
      7'd7:  u = mk(OP_LD,   L_PHI,     L_ZERO,  L_ZERO);
      7'd8:  u = mk(OP_ADD,  L_TAU,     L_ZERO,  L_ZERO);
      7'd9:  u = mk(OP_ADD,  L_MU_H,    L_ZERO,  L_ZERO);
      7'd10: u = mk(OP_ST,   L_ZERO,    L_ZERO,  L_K3);
      // totals, floored at one
      7'd11: u = mk(OP_LD,   L_H0,      L_ZERO,  L_ZERO);
      7'd12: u = mk(OP_ADD,  L_H1,      L_ZERO,  L_ZERO);
      7'd13: u = mk(OP_ADD,  L_H2,      L_ZERO,  L_ZERO);
      7'd14: u = mk(OP_ADD,  L_H3,      L_ZERO,  L_ZERO);
      7'd15: u = mk(OP_ADD,  L_H4,      L_ZERO,  L_ZERO);
      7'd16: u = mk(OP_STF,  L_ZERO,    L_ZERO,  L_NH);
      7'd17: u = mk(OP_LD,   L_R0,      L_ZERO,  L_ZERO);
      7'd18: u = mk(OP_ADD,  L_R1,      L_ZERO,  L_ZERO);
      7'd19: u = mk(OP_ADD,  L_R2,      L_ZERO,  L_ZERO);
      7'd20: u = mk(OP_STF,  L_ZERO,    L_ZERO,  L_NR);
      // infectious fractions
      7'd21: u = mk(OP_DIV,  L_R2,      L_NR,    L_RATIO_R);
      7'd22: u = mk(OP_DIV,  L_H2,      L_NH,    L_RATIO_H);
      // forces of infection
      7'd23: u = mk(OP_LD,   L_ZERO,    L_ZERO,  L_ZERO);
      7'd24: u = mk(OP_MAC,  L_RATIO_R, L_BETA1, L_ZERO);
      7'd25: u = mk(OP_MAC,  L_RATIO_H, L_BETA2, L_ZERO);
      7'd26: u = mk(OP_ST,   L_ZERO,    L_ZERO,  L_FOI_H);
      7'd27: u = mk(OP_LD,   L_ZERO,    L_ZERO,  L_ZERO);
      7'd28: u = mk(OP_MAC,  L_RATIO_R, L_BETA3, L_ZERO);
      7'd29: u = mk(OP_ST,   L_ZERO,    L_ZERO,  L_FOI_R);
      7'd30: u = mk(OP_LD,   L_ZERO,    L_ZERO,  L_ZERO);
      7'd31: u = mk(OP_MAC,  L_FOI_H,   L_H0,    L_ZERO);
      7'd32: u = mk(OP_ST,   L_ZERO,    L_ZERO,  L_INF_H);
      7'd33: u = mk(OP_LD,   L_ZERO,    L_ZERO,  L_ZERO);
      7'd34: u = mk(OP_MAC,  L_FOI_R,   L_R0,    L_ZERO);
      7'd35: u = mk(OP_ST,   L_ZERO,    L_ZERO,  L_INF_R);
      // human derivatives
      7'd36: u = mk(OP_LD,   L_THETA_H, L_ZERO,  L_ZERO);
      7'd37: u = mk(OP_SUB,  L_INF_H,   L_ZERO,  L_ZERO);
      7'd38: u = mk(OP_MSUB, L_H0,      L_MU_H,  L_ZERO);
      7'd39: u = mk(OP_MAC,  L_H3,      L_PHI,   L_ZERO);
      7'd40: u = mk(OP_ST,   L_ZERO,    L_ZERO,  L_D0);
      7'd41: u = mk(OP_LD,   L_INF_H,   L_ZERO,  L_ZERO);
      7'd42: u = mk(OP_MSUB, L_H1,      L_K1,    L_ZERO);
      7'd43: u = mk(OP_ADD,  L_IMP,     L_ZERO,  L_ZERO);
      7'd44: u = mk(OP_ST,   L_ZERO,    L_ZERO,  L_D1);
      7'd45: u = mk(OP_LD,   L_ZERO,    L_ZERO,  L_ZERO);
      7'd46: u = mk(OP_MAC,  L_H1,      L_A1,    L_ZERO);
      7'd47: u = mk(OP_MSUB, L_H2,      L_K2,    L_ZERO);
      7'd48: u = mk(OP_ST,   L_ZERO,    L_ZERO,  L_D2);
      7'd49: u = mk(OP_LD,   L_ZERO,    L_ZERO,  L_ZERO);
      7'd50: u = mk(OP_MAC,  L_H1,      L_A2,    L_ZERO);
      7'd51: u = mk(OP_MSUB, L_H3,      L_K3,    L_ZERO);
      7'd52: u = mk(OP_ST,   L_ZERO,    L_ZERO,  L_D3);
      7'd53: u = mk(OP_LD,   L_ZERO,    L_ZERO,  L_ZERO);
      7'd54: u = mk(OP_MAC,  L_H2,      L_NU,    L_ZERO);
      7'd55: u = mk(OP_MAC,  L_H3,      L_TAU,   L_ZERO);
      7'd56: u = mk(OP_MSUB, L_H4,      L_MU_H,  L_ZERO);
      7'd57: u = mk(OP_ST,   L_ZERO,    L_ZERO,  L_D4);
      // rodent derivatives
      7'd58: u = mk(OP_LD,   L_THETA_R, L_ZERO,  L_ZERO);
      7'd59: u = mk(OP_SUB,  L_INF_R,   L_ZERO,  L_ZERO);
      7'd60: u = mk(OP_MSUB, L_R0,      L_MU_R,  L_ZERO);
      7'd61: u = mk(OP_ST,   L_ZERO,    L_ZERO,  L_D5);
      7'd62: u = mk(OP_LD,   L_INF_R,   L_ZERO,  L_ZERO);
      7'd63: u = mk(OP_MSUB, L_R1,      L_K4,    L_ZERO);
      7'd64: u = mk(OP_ST,   L_ZERO,    L_ZERO,  L_D6);
      7'd65: u = mk(OP_LD,   L_ZERO,    L_ZERO,  L_ZERO);
      7'd66: u = mk(OP_MAC,  L_R1,      L_ALPHA3, L_ZERO);
      7'd67: u = mk(OP_MSUB, L_R2,      L_K5,    L_ZERO);
      7'd68: u = mk(OP_ST,   L_ZERO,    L_ZERO,  L_D7);
      // euler updates with saturation
      7'd69: u = mk(OP_LD,   L_H0,      L_ZERO,  L_ZERO);
      7'd70: u = mk(OP_MAC,  L_D0,      L_STEP,  L_ZERO);
      7'd71: u = mk(OP_SAT,  L_ZERO,    L_ZERO,  L_H0);
      7'd72: u = mk(OP_LD,   L_H1,      L_ZERO,  L_ZERO);
      7'd73: u = mk(OP_MAC,  L_D1,      L_STEP,  L_ZERO);
      7'd74: u = mk(OP_SAT,  L_ZERO,    L_ZERO,  L_H1);
      7'd75: u = mk(OP_LD,   L_H2,      L_ZERO,  L_ZERO);
      7'd76: u = mk(OP_MAC,  L_D2,      L_STEP,  L_ZERO);
      7'd77: u = mk(OP_SAT,  L_ZERO,    L_ZERO,  L_H2);
      7'd78: u = mk(OP_LD,   L_H3,      L_ZERO,  L_ZERO);
      7'd79: u = mk(OP_MAC,  L_D3,      L_STEP,  L_ZERO);
      7'd80: u = mk(OP_SAT,  L_ZERO,    L_ZERO,  L_H3);
      7'd81: u = mk(OP_LD,   L_H4,      L_ZERO,  L_ZERO);
      7'd82: u = mk(OP_MAC,  L_D4,      L_STEP,  L_ZERO);
      7'd83: u = mk(OP_SAT,  L_ZERO,    L_ZERO,  L_H4);
      7'd84: u = mk(OP_LD,   L_R0,      L_ZERO,  L_ZERO);
      7'd85: u = mk(OP_MAC,  L_D5,      L_STEP,  L_ZERO);
      7'd86: u = mk(OP_SAT,  L_ZERO,    L_ZERO,  L_R0);
      7'd87: u = mk(OP_LD,   L_R1,      L_ZERO,  L_ZERO);
      7'd88: u = mk(OP_MAC,  L_D6,      L_STEP,  L_ZERO);
      7'd89: u = mk(OP_SAT,  L_ZERO,    L_ZERO,  L_R1);
      7'd90: u = mk(OP_LD,   L_R2,      L_ZERO,  L_ZERO);
      7'd91: u = mk(OP_MAC,  L_D7,      L_STEP,  L_ZERO);
      7'd92: u = mk(OP_SAT,  L_ZERO,    L_ZERO,  L_R2);
      default: u = mk(OP_END, L_ZERO, L_ZERO, L_ZERO);
    endcase
    return u;
  endfunction

endpackage

/* sv/seir_mul.sv */
`timescale 1ns / 1ps
module seir_mul
  import seir_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [47:0] b,
  output logic               done,
  output logic signed [63:0] p
);

  logic [63:0]  ma;
  logic [47:0]  mb;
  logic         neg;
  logic [111:0] prod;
  logic [1:0]   cnt;
  logic         busy;
  logic         fin;
  logic [79:0]  part;
  logic [63:0]  mag;

  // one 64x16 partial product per cycle, high chunk first
  assign part = ma * mb[47:32];

  // (a*b) >> 28 on magnitudes, clamped to 2^58
  always_comb begin
    if (|prod[111:86]) begin
      mag = 64'h0400_0000_0000_0000;
    end else begin
      mag = {6'b0, prod[85:28]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 2'd1;
        if (cnt == 2'd2) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  // operand and accumulator registers
  always_ff @(posedge clk) begin
    if (start) begin
      ma   <= a[63] ? 64'(-a) : 64'(a);
      mb   <= b[47] ? 48'(-b) : 48'(b);
      neg  <= a[63] ^ b[47];
      prod <= '0;
    end else if (busy) begin
      prod <= (prod << 16) + {32'b0, part};
      mb   <= mb << 16;
    end
    if (fin) begin
      p <= neg ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

/* sv/seir_div.sv */
`timescale 1ns / 1ps
module seir_div
  import seir_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] num,
  input  logic signed [63:0] den,
  output logic               done,
  output logic signed [63:0] q
);

  logic [DIV_BITS-1:0] dvd;
  logic [DIV_BITS-1:0] quo;
  logic [43:0]         rem;
  logic [43:0]         dv;
  logic [6:0]          cnt;
  logic                busy;
  logic                fin;
  logic                neg;
  logic [63:0]         nmag;
  logic [44:0]         trial;
  logic                fits;
  logic [63:0]         mag;

  assign nmag  = num[63] ? 64'(-num) : 64'(num);
  assign trial = {rem, dvd[DIV_BITS-1]};
  assign fits  = trial >= {1'b0, dv};

  // quotient clamped to 2^58
  always_comb begin
    if (|quo[DIV_BITS-1:58]) begin
      mag = 64'h0400_0000_0000_0000;
    end else begin
      mag = {6'b0, quo[57:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= fin;
      fin  <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 7'd1;
        if (cnt == 7'(DIV_BITS - 1)) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {nmag[39:0], 28'b0};
      quo <= '0;
      rem <= '0;
      dv  <= den[43:0];
      neg <= num[63];
    end else if (busy) begin
      dvd <= dvd << 1;
      quo <= {quo[DIV_BITS-2:0], fits};
      rem <= fits ? 44'(trial - {1'b0, dv}) : trial[43:0];
    end
    if (fin) begin
      q <= neg ? -$signed(mag) : $signed(mag);
    end
  end

endmodule

/* sv/seir_euler_step.sv */
`timescale 1ns / 1ps
// channel   direction  handshake                     payload
// item      in         item_valid / item_ready       seir_in_t
// result    out        result_valid / result_ready   seir_out_t
// cfg       in         cfg_we (no wait)              cfg_index, cfg_data
//
// a load item is answered in the cycle after it is taken.
// a step item runs a 93-op microprogram on one shared 64x48 multiplier
// (27 products) and one radix-2 divider (used twice); result_valid rises
// once the microprogram has reached its end op.
// item_ready is high only while idle; the result holds until result_ready.
// rst is synchronous and clears all compartments to zero and the configuration
// registers to their defaults.
module seir_euler_step
  import seir_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  seir_in_t    item,
  output logic        result_valid,
  input  logic        result_ready,
  output seir_out_t   result,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  state_t state, state_next;
  logic [PC_W-1:0] pc;
  uop_t uop;

  logic [31:0] cfg [NUM_CFG];
  logic signed [39:0] h [5];
  logic signed [39:0] r [3];
  logic signed [63:0] d [8];
  logic signed [63:0] nh, nr, ratio_r, ratio_h, foi_h, foi_r, inf_h, inf_r;
  logic signed [63:0] k1, k2, k3;
  logic [31:0] step, beta2;
  logic signed [63:0] acc, acc_next;
  logic clip;

  logic signed [63:0] va, vb;
  logic mul_start, mul_done, div_start, div_done;
  logic signed [63:0] mul_p, div_q;
  logic wr_en;
  logic signed [63:0] wr_val;
  logic signed [63:0] sat_val;
  logic sat_hit;
  logic accept_in;
  logic signed [40:0] active_sum;

  function automatic logic signed [63:0] pick(input loc_t sel);
    logic signed [63:0] v;
    v = '0;
    case (sel)
      L_ZERO:    v = '0;
      L_H0:      v = 64'(h[0]);
      L_H1:      v = 64'(h[1]);
      L_H2:      v = 64'(h[2]);
      L_H3:      v = 64'(h[3]);
      L_H4:      v = 64'(h[4]);
      L_R0:      v = 64'(r[0]);
      L_R1:      v = 64'(r[1]);
      L_R2:      v = 64'(r[2]);
      L_NH:      v = nh;
      L_NR:      v = nr;
      L_RATIO_R: v = ratio_r;
      L_RATIO_H: v = ratio_h;
      L_FOI_H:   v = foi_h;
      L_FOI_R:   v = foi_r;
      L_INF_H:   v = inf_h;
      L_INF_R:   v = inf_r;
      L_K1:      v = k1;
      L_K2:      v = k2;
      L_K3:      v = k3;
      L_D0:      v = d[0];
      L_D1:      v = d[1];
      L_D2:      v = d[2];
      L_D3:      v = d[3];
      L_D4:      v = d[4];
      L_D5:      v = d[5];
      L_D6:      v = d[6];
      L_D7:      v = d[7];
      L_STEP:    v = $signed({32'b0, step});
      L_BETA1:   v = $signed({32'b0, cfg[REG_BETA1]});
      L_BETA2:   v = $signed({32'b0, beta2});
      L_BETA3:   v = $signed({32'b0, cfg[REG_BETA3]});
      L_A1:      v = $signed({32'b0, cfg[REG_A1]});
      L_A2:      v = $signed({32'b0, cfg[REG_A2]});
      L_NU:      v = $signed({32'b0, cfg[REG_NU]});
      L_TAU:     v = $signed({32'b0, cfg[REG_TAU]});
      L_PHI:     v = $signed({32'b0, cfg[REG_PHI]});
      L_IMP:     v = $signed({32'b0, cfg[REG_IMP]});
      L_MU_H:    v = $signed(MU_H);
      L_MU_R:    v = $signed(MU_R);
      L_ALPHA3:  v = $signed(ALPHA3);
      L_K4:      v = $signed(K4);
      L_K5:      v = $signed(K5);
      L_THETA_H: v = $signed(THETA_H);
      L_THETA_R: v = $signed(THETA_R);
      default:   v = '0;
    endcase
    return v;
  endfunction

  assign accept_in = item_valid && item_ready;
  assign uop = seir_ucode(pc);

  // operand selection
  always_comb begin
    va = pick(uop.a);
    vb = pick(uop.b);
  end

  seir_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (va),
    .b     (vb[47:0]),
    .done  (mul_done),
    .p     (mul_p)
  );

  seir_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (va),
    .den   (vb),
    .done  (div_done),
    .q     (div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept_in) begin
          state_next = (item.kind == KIND_STEP) ? ST_EXEC : ST_OUT;
        end
      end
      ST_EXEC: begin
        unique case (uop.op)
          OP_END:          state_next = ST_OUT;
          OP_MAC, OP_MSUB: state_next = ST_WAIT_MUL;
          OP_DIV:          state_next = ST_WAIT_DIV;
          default:         state_next = ST_EXEC;
        endcase
      end
      ST_WAIT_MUL: if (mul_done) state_next = ST_EXEC;
      ST_WAIT_DIV: if (div_done) state_next = ST_EXEC;
      ST_OUT:      if (result_ready) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // handshake and unit starts
  always_comb begin
    item_ready   = (state == ST_IDLE);
    result_valid = (state == ST_OUT);
    mul_start    = (state == ST_EXEC) && (uop.op == OP_MAC || uop.op == OP_MSUB);
    div_start    = (state == ST_EXEC) && (uop.op == OP_DIV);
  end

  // saturation to the 40-bit compartment range
  always_comb begin
    sat_hit = 1'b1;
    if (acc > POP_MAX) begin
      sat_val = POP_MAX;
    end else if (acc < POP_MIN) begin
      sat_val = POP_MIN;
    end else begin
      sat_val = acc;
      sat_hit = 1'b0;
    end
  end

  // accumulator and write-back selection
  always_comb begin
    acc_next = acc;
    wr_en    = 1'b0;
    wr_val   = acc;
    if (state == ST_EXEC) begin
      unique case (uop.op)
        OP_LD:  acc_next = va;
        OP_ADD: acc_next = acc + va;
        OP_SUB: acc_next = acc - va;
        OP_ST:  wr_en = 1'b1;
        OP_STF: begin
          wr_en  = 1'b1;
          wr_val = (acc < ONE_Q16) ? ONE_Q16 : acc;
        end
        OP_SAT: begin
          wr_en  = 1'b1;
          wr_val = sat_val;
        end
        default: ;
      endcase
    end else if (state == ST_WAIT_MUL && mul_done) begin
      acc_next = (uop.op == OP_MSUB) ? acc - mul_p : acc + mul_p;
    end else if (state == ST_WAIT_DIV && div_done) begin
      wr_en  = 1'b1;
      wr_val = div_q;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= '0;
      clip  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept_in) begin
        pc   <= '0;
        clip <= 1'b0;
      end else if ((state == ST_EXEC && !mul_start && !div_start && uop.op != OP_END)
                   || (state == ST_WAIT_MUL && mul_done)
                   || (state == ST_WAIT_DIV && div_done)) begin
        pc <= pc + 7'd1;
      end
      if (state == ST_EXEC && uop.op == OP_SAT && sat_hit) begin
        clip <= 1'b1;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg[i] <= CFG_RESET[i];
      end
    end else if (cfg_we) begin
      cfg[cfg_index] <= cfg_data;
    end
  end

  // compartments: load, reset, or write-back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 5; i++) h[i] <= '0;
      for (int i = 0; i < 3; i++) r[i] <= '0;
    end else if (accept_in && item.kind == KIND_LOAD) begin
      h[0] <= item.susceptible_humans;
      h[1] <= item.exposed_humans;
      h[2] <= item.infectious_humans;
      h[3] <= item.isolated_humans;
      h[4] <= item.recovered_humans;
      r[0] <= item.susceptible_rodents;
      r[1] <= item.exposed_rodents;
      r[2] <= item.infectious_rodents;
    end else if (wr_en) begin
      case (uop.d)
        L_H0:    h[0] <= wr_val[39:0];
        L_H1:    h[1] <= wr_val[39:0];
        L_H2:    h[2] <= wr_val[39:0];
        L_H3:    h[3] <= wr_val[39:0];
        L_H4:    h[4] <= wr_val[39:0];
        L_R0:    r[0] <= wr_val[39:0];
        L_R1:    r[1] <= wr_val[39:0];
        L_R2:    r[2] <= wr_val[39:0];
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    acc <= acc_next;
    if (accept_in) begin
      step  <= item.step_size;
      beta2 <= item.contact_rate_human;
    end
    if (wr_en) begin
      case (uop.d)
        L_NH:      nh      <= wr_val;
        L_NR:      nr      <= wr_val;
        L_RATIO_R: ratio_r <= wr_val;
        L_RATIO_H: ratio_h <= wr_val;
        L_FOI_H:   foi_h   <= wr_val;
        L_FOI_R:   foi_r   <= wr_val;
        L_INF_H:   inf_h   <= wr_val;
        L_INF_R:   inf_r   <= wr_val;
        L_K1:      k1      <= wr_val;
        L_K2:      k2      <= wr_val;
        L_K3:      k3      <= wr_val;
        L_D0:      d[0]    <= wr_val;
        L_D1:      d[1]    <= wr_val;
        L_D2:      d[2]    <= wr_val;
        L_D3:      d[3]    <= wr_val;
        L_D4:      d[4]    <= wr_val;
        L_D5:      d[5]    <= wr_val;
        L_D6:      d[6]    <= wr_val;
        L_D7:      d[7]    <= wr_val;
        default: ;
      endcase
    end
  end

  // result payload
  assign active_sum = 41'(h[2]) + 41'(h[3]);

  always_comb begin
    result.susceptible_humans_now  = h[0];
    result.exposed_humans_now      = h[1];
    result.infectious_humans_now   = h[2];
    result.isolated_humans_now     = h[3];
    result.recovered_humans_now    = h[4];
    result.susceptible_rodents_now = r[0];
    result.exposed_rodents_now     = r[1];
    result.infectious_rodents_now  = r[2];
    result.saturated               = clip;
    if (active_sum[40] != active_sum[39]) begin
      result.active_infections = active_sum[40] ? POP_MIN[39:0] : POP_MAX[39:0];
    end else begin
      result.active_infections = active_sum[39:0];
    end
  end

  // checks
  a_ready_vs_result: assert property (@(posedge clk) disable iff (rst)
    !(item_ready && result_valid))
    else $error("item taken while a result is pending");

  a_mul_done_state: assert property (@(posedge clk) disable iff (rst)
    mul_done |-> (state == ST_WAIT_MUL))
    else $error("multiplier finished outside its wait state");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_WAIT_DIV))
    else $error("divider finished outside its wait state");

  a_load_result: assert property (@(posedge clk) disable iff (rst)
    (accept_in && item.kind == KIND_LOAD) |=> (result_valid && !result.saturated))
    else $error("load item not answered at once or flagged saturated");

endmodule

/* tb/sv/seir_euler_step_test.sv */
`timescale 1ns / 1ps
module seir_euler_step_test;
  import seir_pkg::*;

  localparam longint CLIP = 64'sd1 <<< 58;
  localparam longint PMAX = 64'sd549755813887;
  localparam longint PMIN = -64'sd549755813888;

  // expected compartment tracker and result checker
  class seir_scoreboard;
    longint hum[5];
    longint rod[3];
    logic [31:0] regs[NUM_CFG];
    seir_out_t pending_results[$];
    int errors;

    function new();
      errors = 0;
      for (int i = 0; i < 5; i++) hum[i] = 0;
      for (int i = 0; i < 3; i++) rod[i] = 0;
      for (int i = 0; i < NUM_CFG; i++) regs[i] = CFG_RESET[i];
    endfunction

    // (a*b)>>s on magnitudes, truncated, clamped
    function longint fx_mul(longint a, longint b, int s);
      logic [127:0] p;
      logic [127:0] r;
      logic [63:0] ua;
      logic [63:0] ub;
      ua = a < 0 ? -a : a;
      ub = b < 0 ? -b : b;
      p = {64'd0, ua} * {64'd0, ub};
      r = p >> s;
      if (r > 128'(CLIP)) r = 128'(CLIP);
      return ((a < 0) != (b < 0)) ? -longint'(r[63:0]) : longint'(r[63:0]);
    endfunction

    // (num<<s)/den on magnitudes, clamped
    function longint fx_div(longint num, longint den, int s);
      logic [127:0] q;
      logic [63:0] m;
      m = num < 0 ? -num : num;
      q = ({64'd0, m} << s) / {64'd0, den};
      if (q >= 128'(CLIP)) q = 128'(CLIP);
      return num < 0 ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function longint clamp40(longint v, inout bit clip);
      if (v > PMAX) begin clip = 1; return PMAX; end
      if (v < PMIN) begin clip = 1; return PMIN; end
      return v;
    endfunction

    function void note_item(seir_in_t it);
      seir_out_t o;
      bit clip;
      bit junk;
      longint nh, nr, rr, rh, fh, fr, ih, ir, st, b2;
      longint a1, a2, nu, tau, phi;
      longint dh[5];
      longint dr[3];
      clip = 0;
      junk = 0;
      if (it.kind == KIND_LOAD) begin
        hum[0] = it.susceptible_humans;
        hum[1] = it.exposed_humans;
        hum[2] = it.infectious_humans;
        hum[3] = it.isolated_humans;
        hum[4] = it.recovered_humans;
        rod[0] = it.susceptible_rodents;
        rod[1] = it.exposed_rodents;
        rod[2] = it.infectious_rodents;
      end else begin
        st = it.step_size;
        b2 = it.contact_rate_human;
        a1 = regs[REG_A1];
        a2 = regs[REG_A2];
        nu = regs[REG_NU];
        tau = regs[REG_TAU];
        phi = regs[REG_PHI];
        nh = hum[0] + hum[1] + hum[2] + hum[3] + hum[4];
        nr = rod[0] + rod[1] + rod[2];
        if (nh < ONE_Q16) nh = ONE_Q16;
        if (nr < ONE_Q16) nr = ONE_Q16;
        rr = fx_div(rod[2], nr, 28);
        rh = fx_div(hum[2], nh, 28);
        fh = fx_mul(rr, longint'(regs[REG_BETA1]), 28) + fx_mul(rh, b2, 28);
        fr = fx_mul(rr, longint'(regs[REG_BETA3]), 28);
        ih = fx_mul(fh, hum[0], 28);
        ir = fx_mul(fr, rod[0], 28);
        dh[0] = longint'(THETA_H) - ih - fx_mul(hum[0], MU_H, 28) + fx_mul(hum[3], phi, 28);
        dh[1] = ih - fx_mul(hum[1], a1 + a2 + longint'(MU_H), 28) + longint'(regs[REG_IMP]);
        dh[2] = fx_mul(hum[1], a1, 28) - fx_mul(hum[2], longint'(MU_H) + nu, 28);
        dh[3] = fx_mul(hum[1], a2, 28) - fx_mul(hum[3], phi + tau + longint'(MU_H), 28);
        dh[4] = fx_mul(hum[2], nu, 28) + fx_mul(hum[3], tau, 28) - fx_mul(hum[4], MU_H, 28);
        dr[0] = longint'(THETA_R) - ir - fx_mul(rod[0], MU_R, 28);
        dr[1] = ir - fx_mul(rod[1], MU_R + ALPHA3, 28);
        dr[2] = fx_mul(rod[1], ALPHA3, 28) - fx_mul(rod[2], MU_R + DELTA_R, 28);
        for (int i = 0; i < 5; i++) hum[i] = clamp40(hum[i] + fx_mul(dh[i], st, 28), clip);
        for (int i = 0; i < 3; i++) rod[i] = clamp40(rod[i] + fx_mul(dr[i], st, 28), clip);
      end
      o.susceptible_humans_now = hum[0][39:0];
      o.exposed_humans_now = hum[1][39:0];
      o.infectious_humans_now = hum[2][39:0];
      o.isolated_humans_now = hum[3][39:0];
      o.recovered_humans_now = hum[4][39:0];
      o.susceptible_rodents_now = rod[0][39:0];
      o.exposed_rodents_now = rod[1][39:0];
      o.infectious_rodents_now = rod[2][39:0];
      o.active_infections = 40'(clamp40(hum[2] + hum[3], junk));
      o.saturated = clip;
      pending_results = {pending_results, o};
    endfunction

    function void field(string nm, logic [39:0] e, logic [39:0] a);
      if (e !== a) begin
        $display("%0t: %s expected %h actual %h", $time, nm, e, a);
        errors++;
      end
    endfunction

    function void check_result(seir_out_t a);
      seir_out_t e;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, a);
        errors++;
        return;
      end
      e = pending_results.pop_front();
      field("susceptible_humans", e.susceptible_humans_now, a.susceptible_humans_now);
      field("exposed_humans", e.exposed_humans_now, a.exposed_humans_now);
      field("infectious_humans", e.infectious_humans_now, a.infectious_humans_now);
      field("isolated_humans", e.isolated_humans_now, a.isolated_humans_now);
      field("recovered_humans", e.recovered_humans_now, a.recovered_humans_now);
      field("susceptible_rodents", e.susceptible_rodents_now, a.susceptible_rodents_now);
      field("exposed_rodents", e.exposed_rodents_now, a.exposed_rodents_now);
      field("infectious_rodents", e.infectious_rodents_now, a.infectious_rodents_now);
      field("active_infections", e.active_infections, a.active_infections);
      field("saturated", 40'(e.saturated), 40'(a.saturated));
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic item_valid = 0;
  logic item_ready;
  seir_in_t item = '0;
  logic result_valid;
  logic result_ready = 0;
  seir_out_t result;
  logic cfg_we = 0;
  logic [2:0] cfg_index = REG_BETA1;
  logic [31:0] cfg_data = '0;
  bit stim_done = 0;
  seir_scoreboard book = new();

  seir_euler_step dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 400);
  endfunction

  // result side: random stalls, check on each accepted result
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) book.check_result(result);
  end

  initial begin
    int g;
    forever begin
      @(negedge clk);
      g = pick_gap();
      if (g > 0 && !stim_done) begin
        result_ready <= 0;
        repeat (g) @(negedge clk);
      end
      result_ready <= 1;
    end
  end

  // valid stays high into the next item when there is no gap
  task automatic send_item(seir_in_t it);
    int g;
    g = pick_gap();
    if (g > 0) begin
      item_valid <= 0;
      repeat (g) @(negedge clk);
    end
    item <= it;
    item_valid <= 1;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    book.note_item(it);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] v);
    item_valid <= 0;
    // let the last result drain first
    while (book.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    book.regs[idx] = v;
  endtask

  function automatic logic [39:0] rand_pop();
    case ($urandom_range(0, 5))
      0: return 40'h7FFFFFFFFF;
      1: return 40'h8000000000;
      2: return 40'({$urandom, $urandom});
      3: return 40'($urandom_range(0, 2000000)) << 16;
      4: return 40'($urandom_range(0, 65535));
      default: return 40'($urandom_range(0, 50000)) << 16;
    endcase
  endfunction

  function automatic logic [31:0] rand_rate();
    case ($urandom_range(0, 4))
      0: return 32'hFFFFFFFF;
      1: return 32'h0;
      2: return $urandom;
      default: return $urandom_range(0, 32'h0400_0000);
    endcase
  endfunction

  function automatic seir_in_t rand_load();
    seir_in_t it;
    it = '0;
    it.kind = KIND_LOAD;
    it.step_size = $urandom;
    it.contact_rate_human = $urandom;
    it.susceptible_humans = rand_pop();
    it.exposed_humans = rand_pop();
    it.infectious_humans = rand_pop();
    it.isolated_humans = rand_pop();
    it.recovered_humans = rand_pop();
    it.susceptible_rodents = rand_pop();
    it.exposed_rodents = rand_pop();
    it.infectious_rodents = rand_pop();
    return it;
  endfunction

  function automatic seir_in_t rand_step();
    seir_in_t it;
    it = rand_load();
    it.kind = KIND_STEP;
    it.step_size = rand_rate();
    it.contact_rate_human = rand_rate();
    return it;
  endfunction

  initial begin
    seir_in_t it;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: step from reset, realistic load, extremes, tiny totals
    it = rand_step();
    it.step_size = 32'h1000_0000;
    it.contact_rate_human = 32'h0400_0000;
    send_item(it);
    it = '0;
    it.kind = KIND_LOAD;
    it.susceptible_humans = 40'd99990 << 16;
    it.infectious_humans = 40'd10 << 16;
    it.susceptible_rodents = 40'd9000 << 16;
    it.infectious_rodents = 40'd1000 << 16;
    send_item(it);
    it.kind = KIND_STEP;
    it.step_size = 32'h1000_0000;
    it.contact_rate_human = 32'h0800_0000;
    send_item(it);
    it.step_size = 32'hFFFFFFFF;
    it.contact_rate_human = 32'hFFFFFFFF;
    send_item(it);
    it = '1;
    it.kind = KIND_LOAD;
    it.susceptible_humans = 40'h7FFFFFFFFF;
    it.infectious_humans = 40'h7FFFFFFFFF;
    it.isolated_humans = 40'h7FFFFFFFFF;
    it.infectious_rodents = 40'h7FFFFFFFFF;
    send_item(it);
    it.kind = KIND_STEP;
    send_item(it);
    it = '0;
    it.kind = KIND_LOAD;
    it.susceptible_humans = 40'h8000000000;
    it.exposed_humans = 40'h8000000000;
    it.infectious_humans = 40'h8000000000;
    it.infectious_rodents = 40'h8000000000;
    send_item(it);
    it.kind = KIND_STEP;
    it.step_size = 32'hFFFFFFFF;
    it.contact_rate_human = 32'hFFFFFFFF;
    send_item(it);
    it = '0;
    it.kind = KIND_LOAD;
    it.infectious_humans = 40'd100;
    it.infectious_rodents = 40'd200;
    send_item(it);
    it.kind = KIND_STEP;
    it.step_size = 32'h1000_0000;
    send_item(it);

    // register phases: extremes, random, then defaults
    for (int ph = 0; ph < 8; ph++) begin
      for (int r = 0; r < NUM_CFG; r++) begin
        case (ph)
          0: write_reg(r[2:0], 32'hFFFFFFFF);
          1: write_reg(r[2:0], 32'h0);
          7: write_reg(r[2:0], CFG_RESET[r]);
          default: write_reg(r[2:0], rand_rate());
        endcase
      end
      for (int n = 0; n < 96; n++) begin
        // mostly a load followed by a run of steps
        if ($urandom_range(0, 9) == 0) send_item(rand_load());
        else send_item(rand_step());
        if (n % 12 == 0) begin
          it = rand_load();
          it.susceptible_humans = 40'($urandom_range(0, 100000)) << 16;
          it.infectious_humans = 40'($urandom_range(0, 100)) << 16;
          it.susceptible_rodents = 40'($urandom_range(0, 10000)) << 16;
          it.infectious_rodents = 40'($urandom_range(0, 1000)) << 16;
          send_item(it);
        end
      end
    end

    item_valid <= 0;
    while (book.pending_results.size() != 0) @(negedge clk);
    stim_done = 1;
    repeat (400) @(negedge clk);
    if (book.errors == 0 && book.pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #60000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
